FILE: src/keyed_record_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Keyed record table assertion macros
// Shared helpers for the concurrent assertions of the keyed record table.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_TABLE_UNIT_DEFINES_SVH

// Assertion checked at every rising clock edge outside reset.
`define KRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion checked at every rising clock edge, reset included.
`define KRT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/krt_pkg.sv
// ----------------------------------------------------------------------------
// Keyed record table package
// Sizes, codes and record type shared by the keyed record table files.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VA_W     = 31;
  localparam int unsigned VB_W     = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECNT_W   = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_DELETE = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VA_W-1:0]  value_a;
    logic [VB_W-1:0]  value_b;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

FILE: src/krt_if.sv
// ----------------------------------------------------------------------------
// Keyed record table channels
// Valid/ready interfaces for the request and the response channel.
// ----------------------------------------------------------------------------
interface krt_req_if
  import krt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  rec_key;
  logic [VA_W-1:0]   value_a;
  logic [VB_W-1:0]   value_b;

  modport source (output valid, output func, output rec_key, output value_a,
                  output value_b, input ready);
  modport sink   (input valid, input func, input rec_key, input value_a,
                  input value_b, output ready);
endinterface

interface krt_rsp_if
  import krt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ECNT_W-1:0]   entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

FILE: src/krt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/keyed_record_table_unit.sv
// ----------------------------------------------------------------------------
// Keyed record table unit
// Unsorted table of records searched linearly, with add, update and delete.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (func, rec_key, value_a, value_b); each gives one
// response on rsp_o carrying a status and the entry count after the request.
// The block takes one request at a time: req_i.ready is high only while the
// sequencer is idle. All records sit in one RAM with a single read port, and
// every record visited is first read and then compared or moved.
// An add, an unused code, or an update or delete on an empty table goes
// straight from acceptance to the response step. An update or delete reads
// the records in turn and compares each key until the first match or the
// end of the table, and a delete then moves every later record down by one
// position, reading each one and writing it back one place lower.
// The response sits in an output register; a new request is accepted while
// it waits, and the block only holds in its final step if the previous
// response has still not been taken. After reset the table is empty and no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`include "keyed_record_table_unit_defines.svh"

module keyed_record_table_unit
  import krt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  krt_req_if.sink   req_i,
  krt_rsp_if.source rsp_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  status_e            status_q, status_d;
  logic               out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ECNT_W-1:0]  out_count_q;

  logic [FUNC_W-1:0]  func_q;
  logic [KEY_W-1:0]   key_q;
  logic [VA_W-1:0]    va_q;
  logic [VB_W-1:0]    vb_q;

  logic               req_ready;
  logic               load_req;
  logic               out_load;
  logic               out_free;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  rec_t               ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  rec_t               ram_rdata;

  logic [CNT_W-1:0]   scan_nxt;
  logic [CNT_W-1:0]   count_dec;
  logic               key_hit;
  logic               full;
  logic               last;
  logic               more_shift;
  logic               more_after_hit;

  krt_ram #(
    .WIDTH(REC_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign scan_nxt       = scan_q + CNT_W'(1);
  assign count_dec      = count_q - CNT_W'(1);
  assign key_hit        = (ram_rdata.key == key_q);
  assign full           = (count_q == CNT_W'(CAPACITY));
  assign last           = (scan_nxt == count_q);
  assign more_after_hit = (scan_nxt < count_q);
  assign more_shift     = (scan_nxt < count_dec);
  assign out_free       = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (func_e'(req_i.func))
            FUNC_ADD:                 state_d = ST_RESP;
            FUNC_UPDATE, FUNC_DELETE: state_d = (count_q == '0) ? ST_RESP : ST_RD;
            default:                  state_d = ST_RESP;
          endcase
        end
      end
      ST_RD: state_d = ST_CMP;
      ST_CMP: begin
        if (key_hit) begin
          state_d = (func_q == FUNC_DELETE && more_after_hit) ? ST_SH_RD : ST_RESP;
        end else begin
          state_d = last ? ST_RESP : ST_RD;
        end
      end
      ST_SH_RD: state_d = ST_SH_WR;
      ST_SH_WR: state_d = more_shift ? ST_SH_RD : ST_RESP;
      ST_RESP:  state_d = out_free ? ST_IDLE : ST_RESP;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    load_req  = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count_q[IDX_W-1:0];
    ram_wdata = '{key: key_q, value_a: va_q, value_b: vb_q};
    ram_re    = 1'b0;
    ram_raddr = scan_q[IDX_W-1:0];
    scan_d    = scan_q;
    count_d   = count_q;
    status_d  = status_q;
    unique case (state_q)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          load_req = 1'b1;
          scan_d   = '0;
          status_d = STATUS_DONE;
          unique case (func_e'(req_i.func))
            FUNC_ADD: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = '{key: req_i.rec_key, value_a: req_i.value_a,
                              value_b: req_i.value_b};
                count_d   = count_q + CNT_W'(1);
              end
            end
            FUNC_UPDATE, FUNC_DELETE: begin
              if (count_q == '0) begin
                status_d = STATUS_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        ram_re = 1'b1;
      end
      ST_CMP: begin
        if (key_hit) begin
          if (func_q == FUNC_UPDATE) begin
            ram_we    = 1'b1;
            ram_waddr = scan_q[IDX_W-1:0];
          end else if (!more_after_hit) begin
            count_d = count_dec;
          end
        end else begin
          scan_d = scan_nxt;
          if (last) begin
            status_d = STATUS_NOT_FOUND;
          end
        end
      end
      ST_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = scan_nxt[IDX_W-1:0];
      end
      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q[IDX_W-1:0];
        ram_wdata = ram_rdata;
        scan_d    = scan_nxt;
        if (!more_shift) begin
          count_d = count_dec;
        end
      end
      ST_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      status_q    <= STATUS_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      scan_q   <= scan_d;
      status_q <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_req) begin
      func_q <= req_i.func;
      key_q  <= req_i.rec_key;
      va_q   <= req_i.value_a;
      vb_q   <= req_i.value_b;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_count_q  <= ECNT_W'(count_q);
    end
  end

  assign req_i.ready       = req_ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_count = out_count_q;

  `KRT_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY),
    "Entry count exceeds the table capacity.")
  `KRT_ASSERT(a_count_step, clk_i, rst_ni,
    count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1) ||
    count_q == $past(count_q) - CNT_W'(1),
    "Entry count moved by more than one record in a cycle.")
  `KRT_ASSERT(a_accept_leaves_idle, clk_i, rst_ni,
    req_i.valid && req_i.ready |=> state_q != ST_IDLE,
    "Sequencer stayed idle after accepting a request.")
  `KRT_ASSERT(a_resp_loads, clk_i, rst_ni,
    state_q == ST_RESP && out_free |=> rsp_o.valid && state_q == ST_IDLE,
    "Finished request did not reach the response register.")

endmodule
